[design/bilinear_grid_interpolator_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the bilinear grid interpolator
// Shared property forms used by the port-level checker.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_GRID_INTERPOLATOR_CORE_ASSERT_SVH
`define BILINEAR_GRID_INTERPOLATOR_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define BGI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define BGI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after reset is sampled low.
`define BGI_ASSERT_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

[design/bgi_pkg.sv]
// ---------------------------------------------------------------------------
// Bilinear grid interpolator package
// Shared constants, register codes and pipeline types.
// ---------------------------------------------------------------------------
package bgi_pkg;

    localparam int MAX_COLS_DEF      = 16;
    localparam int MAX_ROWS_DEF      = 16;
    localparam int FRACTION_BITS_DEF = 10;

    localparam int CNT_W      = 5;
    localparam int STEP_W     = 15;
    localparam int POS_W      = 16;
    localparam int COORD_W    = 32;
    localparam int SAMPLE_W   = 16;
    localparam int ADDR_IN_W  = 8;
    localparam int OFF_W      = 16;
    localparam int SPAN_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 88;
    localparam int M_DATA_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_COLS     = 3'd0,
        REG_GRID_ROWS     = 3'd1,
        REG_COL_STEP      = 3'd2,
        REG_ROW_STEP      = 3'd3,
        REG_FIRST_COL_POS = 3'd4,
        REG_FIRST_ROW_POS = 3'd5
    } cfg_reg_t;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // Item information that rides along the divider pipeline.
    typedef struct packed {
        logic                        lookup;
        logic [ADDR_IN_W-1:0]        addr;
        logic signed [SAMPLE_W-1:0]  value;
        logic                        sat_x;
        logic                        sat_y;
    } bgi_side_t;

endpackage

[design/bilinear_grid_interpolator_core.sv]
// ---------------------------------------------------------------------------
// Bilinear grid interpolator core
// Stores a row-major grid of signed samples and interpolates lookups.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Transfer carries
//   s_*       in         grid write (tuser = 0) or lookup (tuser = 1)
//   m_*       out        one interpolated sample per lookup
//   cfg_*     in         register write, no handshake, no read-back
//
// One item is accepted every cycle unless m_tready stalls the output. Lookups
// pass the input and offset stages, the bit-serial divider pipeline of
// 16 + FRACTION_BITS stages, the corner read and the blend. Grid writes give
// no result. Reset is synchronous and active low; grid contents are not
// cleared. A stall on m_tready freezes the whole pipeline; s_tready follows it.
// ---------------------------------------------------------------------------
module bilinear_grid_interpolator_core #(
    parameter int MAX_COLS      = bgi_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS      = bgi_pkg::MAX_ROWS_DEF,
    parameter int FRACTION_BITS = bgi_pkg::FRACTION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_addr[7:0], entry_value[23:8], x_pos[55:24], y_pos[87:56]
    input  logic [bgi_pkg::S_DATA_W-1:0]      s_tdata,
    // mode[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // z_value[15:0]
    output logic [bgi_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                              cfg_we,
    input  logic [bgi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bgi_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import bgi_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GIDX_W = (AW > 10) ? AW : 10;
    localparam int FB     = FRACTION_BITS;
    localparam int QW     = OFF_W + FB;

    // Configuration registers.
    logic [CNT_W-1:0]          grid_cols_reg;
    logic [CNT_W-1:0]          grid_rows_reg;
    logic [STEP_W-1:0]         col_step_reg;
    logic [STEP_W-1:0]         row_step_reg;
    logic signed [POS_W-1:0]   first_col_pos_reg;
    logic signed [POS_W-1:0]   first_row_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg     <= CNT_W'(1);
            grid_rows_reg     <= CNT_W'(1);
            col_step_reg      <= '0;
            row_step_reg      <= '0;
            first_col_pos_reg <= '0;
            first_row_pos_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GRID_COLS:     grid_cols_reg     <= cfg_data[CNT_W-1:0];
                REG_GRID_ROWS:     grid_rows_reg     <= cfg_data[CNT_W-1:0];
                REG_COL_STEP:      col_step_reg      <= cfg_data[STEP_W-1:0];
                REG_ROW_STEP:      row_step_reg      <= cfg_data[STEP_W-1:0];
                REG_FIRST_COL_POS: first_col_pos_reg <= cfg_data[POS_W-1:0];
                REG_FIRST_ROW_POS: first_row_pos_reg <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Values derived from the configuration, refreshed every cycle: fast enough
    // if the user changes it only while idle; the block does not enforce that.
    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] n,
                                                   input int max_n);
        logic [CNT_W-1:0] r;
        r = n;
        if (n == '0) begin
            r = CNT_W'(1);
        end else if (32'(n) > max_n) begin
            r = CNT_W'(max_n);
        end
        return r;
    endfunction

    logic [CNT_W-1:0]          cnt_x_next, cnt_y_next;
    logic [SPAN_W-1:0]         span_x_next, span_y_next;
    logic signed [POS_W-1:0]   end_x_next, end_y_next;
    logic [POS_W:0]            diff_x, diff_y;
    logic [OFF_W-1:0]          top_x_next, top_y_next;

    logic [CNT_W-1:0]          cnt_x_reg, cnt_y_reg;
    logic [SPAN_W-1:0]         span_x_reg, span_y_reg;
    logic signed [POS_W-1:0]   end_x_reg, end_y_reg;
    logic [OFF_W-1:0]          top_x_reg, top_y_reg;
    logic                      zero_step_reg;

    assign cnt_x_next  = clamp_cnt(grid_cols_reg, MAX_COLS);
    assign cnt_y_next  = clamp_cnt(grid_rows_reg, MAX_ROWS);
    assign span_x_next = SPAN_W'(cnt_x_next - CNT_W'(1)) * SPAN_W'(col_step_reg);
    assign span_y_next = SPAN_W'(cnt_y_next - CNT_W'(1)) * SPAN_W'(row_step_reg);

    // The span end wraps to 16 bits, so it can land below the first position.
    assign end_x_next  = first_col_pos_reg + signed'(span_x_next[POS_W-1:0]);
    assign end_y_next  = first_row_pos_reg + signed'(span_y_next[POS_W-1:0]);
    assign diff_x      = {end_x_next[POS_W-1], end_x_next}
                       - {first_col_pos_reg[POS_W-1], first_col_pos_reg};
    assign diff_y      = {end_y_next[POS_W-1], end_y_next}
                       - {first_row_pos_reg[POS_W-1], first_row_pos_reg};
    assign top_x_next  = diff_x[POS_W] ? '0 : diff_x[OFF_W-1:0];
    assign top_y_next  = diff_y[POS_W] ? '0 : diff_y[OFF_W-1:0];

    always_ff @(posedge aclk) begin
        cnt_x_reg     <= cnt_x_next;
        cnt_y_reg     <= cnt_y_next;
        span_x_reg    <= span_x_next;
        span_y_reg    <= span_y_next;
        end_x_reg     <= end_x_next;
        end_y_reg     <= end_y_next;
        top_x_reg     <= top_x_next;
        top_y_reg     <= top_y_next;
        zero_step_reg <= (col_step_reg == '0) || (row_step_reg == '0);
    end

    // The whole pipeline moves whenever the output register can take a value.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage A: input register.
    logic                        a_vld_reg;
    logic                        a_mode_reg;
    logic [ADDR_IN_W-1:0]        a_addr_reg;
    logic signed [SAMPLE_W-1:0]  a_value_reg;
    logic signed [COORD_W-1:0]   a_x_reg;
    logic signed [COORD_W-1:0]   a_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_mode_reg  <= s_tuser;
            a_addr_reg  <= s_tdata[7:0];
            a_value_reg <= s_tdata[23:8];
            a_x_reg     <= s_tdata[55:24];
            a_y_reg     <= s_tdata[87:56];
        end
    end

    // Stage B: clamp each coordinate to the span and form its offset.
    function automatic logic [OFF_W-1:0] clamp_off(
        input logic signed [COORD_W-1:0] pos,
        input logic signed [POS_W-1:0]   first,
        input logic signed [POS_W-1:0]   last,
        input logic [OFF_W-1:0]          top
    );
        logic signed [COORD_W-1:0] first_w;
        logic signed [COORD_W-1:0] last_w;
        logic signed [COORD_W-1:0] diff;
        logic [OFF_W-1:0]          r;
        first_w = COORD_W'(first);
        last_w  = COORD_W'(last);
        diff    = pos - first_w;
        if (pos <= first_w) begin
            r = '0;
        end else if (pos > last_w) begin
            r = top;
        end else begin
            r = diff[OFF_W-1:0];
        end
        return r;
    endfunction

    logic [OFF_W-1:0] off_x, off_y;
    logic             b_vld_reg;
    logic [OFF_W-1:0] b_off_x_reg, b_off_y_reg;
    bgi_side_t        b_side_reg;

    assign off_x = clamp_off(a_x_reg, first_col_pos_reg, end_x_reg, top_x_reg);
    assign off_y = clamp_off(a_y_reg, first_row_pos_reg, end_y_reg, top_y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (adv) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    // An offset at or past the last cell start saturates the cell index.
    always_ff @(posedge aclk) begin
        if (adv) begin
            b_off_x_reg       <= off_x;
            b_off_y_reg       <= off_y;
            b_side_reg.lookup <= (a_mode_reg == MODE_LOOKUP);
            b_side_reg.addr   <= a_addr_reg;
            b_side_reg.value  <= a_value_reg;
            b_side_reg.sat_x  <= (SPAN_W'(off_x) >= span_x_reg);
            b_side_reg.sat_y  <= (SPAN_W'(off_y) >= span_y_reg);
        end
    end

    // Divider: offset scaled by the fraction, over the step.
    logic [1:0][QW-1:0]     div_num;
    logic [1:0][STEP_W-1:0] div_den;
    logic [1:0][QW-1:0]     div_quo;
    logic                   div_vld;
    bgi_side_t              div_side;

    assign div_num[0] = {b_off_x_reg, FB'(0)};
    assign div_num[1] = {b_off_y_reg, FB'(0)};
    assign div_den[0] = col_step_reg;
    assign div_den[1] = row_step_reg;

    bgi_div2 #(
        .NUM_W  (QW),
        .DEN_W  (STEP_W),
        .SIDE_W ($bits(bgi_side_t))
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (b_vld_reg),
        .num      (div_num),
        .den      (div_den),
        .side_in  (b_side_reg),
        .out_vld  (div_vld),
        .quo      (div_quo),
        .side_out (div_side)
    );

    // Stage C: cell indices, fractions and the four corner addresses.
    // Grid writes are applied here too, in item order with the reads.
    logic [CNT_W-1:0]   cx1, cx2, ry1, ry2;
    logic [FB-1:0]      fx, fy;
    logic [GIDX_W-1:0]  gaddr [4];
    logic [GIDX_W-1:0]  waddr_w;
    logic               wr_en;

    always_comb begin
        if (div_side.sat_x) begin
            cx1 = cnt_x_reg - CNT_W'(1);
            cx2 = cx1;
            fx  = '0;
        end else begin
            cx1 = div_quo[0][FB +: CNT_W];
            cx2 = cx1 + CNT_W'(1);
            fx  = div_quo[0][FB-1:0];
        end
        if (div_side.sat_y) begin
            ry1 = cnt_y_reg - CNT_W'(1);
            ry2 = ry1;
            fy  = '0;
        end else begin
            ry1 = div_quo[1][FB +: CNT_W];
            ry2 = ry1 + CNT_W'(1);
            fy  = div_quo[1][FB-1:0];
        end
    end

    assign gaddr[0] = GIDX_W'(ry1) * GIDX_W'(cnt_x_reg) + GIDX_W'(cx1);
    assign gaddr[1] = GIDX_W'(ry1) * GIDX_W'(cnt_x_reg) + GIDX_W'(cx2);
    assign gaddr[2] = GIDX_W'(ry2) * GIDX_W'(cnt_x_reg) + GIDX_W'(cx1);
    assign gaddr[3] = GIDX_W'(ry2) * GIDX_W'(cnt_x_reg) + GIDX_W'(cx2);

    // Writes beyond the grid depth are dropped.
    assign waddr_w = GIDX_W'(div_side.addr);
    assign wr_en   = adv && div_vld && !div_side.lookup
                  && (32'(div_side.addr) < DEPTH);

    logic [3:0][SAMPLE_W-1:0] smp;

    for (genvar i = 0; i < 4; i++) begin : g_bank
        bgi_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (wr_en),
            .wr_addr (waddr_w[AW-1:0]),
            .wr_data (div_side.value),
            .rd_en   (adv),
            .rd_addr (gaddr[i][AW-1:0]),
            .rd_data (smp[i])
        );
    end

    logic          c_vld_reg;
    logic [FB-1:0] c_fx_reg, c_fy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (adv) begin
            c_vld_reg <= div_vld && div_side.lookup;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_fx_reg <= fx;
            c_fy_reg <= fy;
        end
    end

    // Stages D to F: weights, weighted samples, sum and output register.
    bgi_blend #(
        .FRACTION_BITS (FB)
    ) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_vld    (c_vld_reg),
        .frac_x    (c_fx_reg),
        .frac_y    (c_fy_reg),
        .zero_step (zero_step_reg),
        .smp       (smp),
        .out_vld   (m_tvalid),
        .z         (m_tdata)
    );

endmodule

[design/bgi_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bgi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/bgi_div2.sv]
// ---------------------------------------------------------------------------
// Two-lane pipelined divider
// Restoring division, one quotient bit per stage, for the x and y lanes.
// ---------------------------------------------------------------------------
module bgi_div2 #(
    parameter int NUM_W  = 26,
    parameter int DEN_W  = 15,
    parameter int SIDE_W = 27
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [1:0][NUM_W-1:0]      num,
    input  logic [1:0][DEN_W-1:0]      den,
    input  logic [SIDE_W-1:0]          side_in,
    output logic                       out_vld,
    output logic [1:0][NUM_W-1:0]      quo,
    output logic [SIDE_W-1:0]          side_out
);

    logic                         vld_reg  [NUM_W];
    logic [SIDE_W-1:0]            side_reg [NUM_W];
    logic [1:0][DEN_W-1:0]        rem_reg  [NUM_W];
    logic [1:0][NUM_W-1:0]        n_reg    [NUM_W];
    logic [1:0][NUM_W-1:0]        q_reg    [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic                  vld_in;
        logic [SIDE_W-1:0]     side_stage;

        if (k == 0) begin : g_first
            assign vld_in     = in_vld;
            assign side_stage = side_in;
        end else begin : g_next
            assign vld_in     = vld_reg[k-1];
            assign side_stage = side_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_stage;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DEN_W-1:0] rem_in;
            logic [NUM_W-1:0] n_in;
            logic [NUM_W-1:0] q_in;
            logic [DEN_W:0]   trial;
            logic [DEN_W:0]   diff;
            logic             take;

            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign n_in   = num[l];
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = rem_reg[k-1][l];
                assign n_in   = n_reg[k-1][l];
                assign q_in   = q_reg[k-1][l];
            end

            assign trial = {rem_in, n_in[NUM_W-1]};
            assign diff  = trial - {1'b0, den[l]};
            assign take  = (trial >= {1'b0, den[l]});

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k][l] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    n_reg[k][l]   <= {n_in[NUM_W-2:0], 1'b0};
                    q_reg[k][l]   <= {q_in[NUM_W-2:0], take};
                end
            end
        end
    end

    assign out_vld  = vld_reg[NUM_W-1];
    assign quo      = q_reg[NUM_W-1];
    assign side_out = side_reg[NUM_W-1];

endmodule

[design/bgi_blend.sv]
// ---------------------------------------------------------------------------
// Bilinear blend pipeline
// Corner weights, weighted samples and the final sum with scaling.
// ---------------------------------------------------------------------------
module bgi_blend #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_vld,
    input  logic [FRACTION_BITS-1:0]               frac_x,
    input  logic [FRACTION_BITS-1:0]               frac_y,
    input  logic                                   zero_step,
    input  logic [3:0][bgi_pkg::SAMPLE_W-1:0]      smp,
    output logic                                   out_vld,
    output logic [bgi_pkg::SAMPLE_W-1:0]           z
);

    import bgi_pkg::*;

    localparam int FB    = FRACTION_BITS;
    localparam int W_W   = FB + 1;
    localparam int MUL_W = 2 * FB + 2;
    localparam int PW    = FB + 2 + SAMPLE_W;
    localparam int ACC_W = PW + 2;

    logic [W_W-1:0]               one_m_fx;
    logic [W_W-1:0]               one_m_fy;
    logic [W_W-1:0]               fx_w;
    logic [W_W-1:0]               fy_w;
    logic [3:0][MUL_W-1:0]        wmul;

    logic                         vld1_reg;
    logic [3:0][W_W-1:0]          w_reg;
    logic [3:0][SAMPLE_W-1:0]     smp_reg;

    logic                         vld2_reg;
    logic signed [PW-1:0]         prod_reg [4];

    logic                         vld3_reg;
    logic [SAMPLE_W-1:0]          z_reg;

    logic signed [ACC_W-1:0]      acc;
    logic signed [ACC_W-1:0]      acc_adj;
    logic signed [ACC_W-1:0]      acc_shr;

    assign fx_w     = W_W'(frac_x);
    assign fy_w     = W_W'(frac_y);
    assign one_m_fx = (W_W'(1) << FB) - fx_w;
    assign one_m_fy = (W_W'(1) << FB) - fy_w;

    assign wmul[0] = MUL_W'(one_m_fx) * MUL_W'(one_m_fy);
    assign wmul[1] = MUL_W'(fx_w) * MUL_W'(one_m_fy);
    assign wmul[2] = MUL_W'(one_m_fx) * MUL_W'(fy_w);
    assign wmul[3] = MUL_W'(fx_w) * MUL_W'(fy_w);

    // Weights are non-negative, so dividing by the scale is a plain shift.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                w_reg[i]   <= wmul[i][2*FB:FB];
                smp_reg[i] <= smp[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                prod_reg[i] <= PW'(signed'({1'b0, w_reg[i]}))
                             * PW'(signed'(smp_reg[i]));
            end
        end
    end

    assign acc = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1])
               + ACC_W'(prod_reg[2]) + ACC_W'(prod_reg[3]);

    // Bias negative sums so the arithmetic shift truncates toward zero.
    assign acc_adj = acc[ACC_W-1] ? (acc + ACC_W'((1 << FB) - 1)) : acc;
    assign acc_shr = acc_adj >>> FB;

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg <= zero_step ? '0 : acc_shr[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    assign out_vld = vld3_reg;
    assign z       = z_reg;

endmodule

[design/bgi_checker.sv]
// ---------------------------------------------------------------------------
// Bilinear grid interpolator port checker
// Watches the top-level ports for handshake and reset behavior.
// ---------------------------------------------------------------------------
`include "bilinear_grid_interpolator_core_assert.svh"

module bgi_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bgi_pkg::M_DATA_W-1:0]   m_tdata
);

    // A stalled result stays offered.
    `BGI_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")

    // A stalled result keeps its value.
    `BGI_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata changed while stalled")

    // The input side is open whenever the output register can move.
    `BGI_ASSERT_SAME(a_ready_open, aclk, aresetn, !m_tvalid || m_tready, s_tready, "s_tready low with a free output")

    // No result is offered right after reset.
    `BGI_ASSERT_RESET(a_reset_idle, aclk, aresetn, !m_tvalid, "m_tvalid high after reset")

endmodule

bind bilinear_grid_interpolator_core bgi_checker u_bgi_checker (.*);

[test/bgi_result_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Result checker for the bilinear grid interpolator
// Watches every channel of the core, keeps its own copy of the grid and the
// registers, computes the sample each lookup must give, and compares it
// with the sample the core returns, in order.
// ---------------------------------------------------------------------------
module bgi_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bgi_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bgi_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_we,
    input  logic [bgi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgi_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending_count,
    output int                             lookups_checked
);

    import bgi_pkg::*;

    localparam longint SCALE = 1024;

    logic signed [SAMPLE_W-1:0] grid_copy [0:255];
    logic [CNT_W-1:0]           cols_reg;
    logic [CNT_W-1:0]           rows_reg;
    logic [STEP_W-1:0]          col_step_reg;
    logic [STEP_W-1:0]          row_step_reg;
    logic signed [POS_W-1:0]    first_col_reg;
    logic signed [POS_W-1:0]    first_row_reg;
    logic signed [15:0]         expected_z [$];

    function automatic int clamp_count(logic [CNT_W-1:0] n, int max_n);
        if (n < 1) return 1;
        if (n > max_n) return max_n;
        return int'(n);
    endfunction

    // Clamps one coordinate and splits its offset into cell and fraction.
    function automatic void find_cell(longint pos, longint first, longint step, int count,
                                      output int lo, output int hi, output longint frac);
        logic [15:0] wrapped;
        longint      span_end, off, scaled, idx;
        wrapped  = 16'(first + longint'(count - 1) * step);
        span_end = longint'($signed(wrapped));
        if (pos < first) pos = first;
        else if (pos > span_end) pos = span_end;
        off = pos - first;
        if (off < 0) off = 0;
        scaled = (off * SCALE) / step;
        idx    = scaled >> 10;
        frac   = scaled & (SCALE - 1);
        if (idx >= count - 1) begin
            lo   = count - 1;
            hi   = lo;
            frac = 0;
        end else begin
            lo = int'(idx);
            hi = lo + 1;
        end
    endfunction

    function automatic logic signed [15:0] interp_point(logic signed [31:0] xp,
                                                        logic signed [31:0] yp);
        int     cols, rows, c0, c1, r0, r1;
        longint fx, fy, acc, z;
        if (col_step_reg == 0 || row_step_reg == 0) return '0;
        cols = clamp_count(cols_reg, MAX_COLS_DEF);
        rows = clamp_count(rows_reg, MAX_ROWS_DEF);
        find_cell(longint'(xp), longint'(first_col_reg), longint'(col_step_reg), cols,
                  c0, c1, fx);
        find_cell(longint'(yp), longint'(first_row_reg), longint'(row_step_reg), rows,
                  r0, r1, fy);
        // Each weight is truncated to the fraction width before it scales a corner.
        acc = (((SCALE - fx) * (SCALE - fy)) / SCALE) * longint'(grid_copy[r0 * cols + c0]);
        acc += ((fx * (SCALE - fy)) / SCALE) * longint'(grid_copy[r0 * cols + c1]);
        acc += (((SCALE - fx) * fy) / SCALE) * longint'(grid_copy[r1 * cols + c0]);
        acc += ((fx * fy) / SCALE) * longint'(grid_copy[r1 * cols + c1]);
        z = acc / SCALE;
        return z[15:0];
    endfunction

    always @(posedge aclk) begin
        logic signed [15:0] want;
        if (!aresetn) begin
            for (int i = 0; i < 256; i++) grid_copy[i] = '0;
            fail_count      = 0;
            lookups_checked = 0;
            cols_reg        = 1;
            rows_reg        = 1;
            col_step_reg    = '0;
            row_step_reg    = '0;
            first_col_reg   = '0;
            first_row_reg   = '0;
            expected_z.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_GRID_COLS:     cols_reg      = cfg_data[CNT_W-1:0];
                    REG_GRID_ROWS:     rows_reg      = cfg_data[CNT_W-1:0];
                    REG_COL_STEP:      col_step_reg  = cfg_data[STEP_W-1:0];
                    REG_ROW_STEP:      row_step_reg  = cfg_data[STEP_W-1:0];
                    REG_FIRST_COL_POS: first_col_reg = cfg_data;
                    REG_FIRST_ROW_POS: first_row_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == MODE_WRITE)
                    grid_copy[s_tdata[7:0]] = s_tdata[23:8];
                else
                    expected_z.push_back(interp_point(s_tdata[55:24], s_tdata[87:56]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_z.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: z=%0d", $signed(m_tdata));
                end else begin
                    want = expected_z.pop_front();
                    lookups_checked++;
                    if (m_tdata !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("z_value mismatch: expected %0d, got %0d",
                                     want, $signed(m_tdata));
                    end
                end
            end
        end
        pending_count <= expected_z.size();
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bilinear grid interpolator testbench
// Fills the grid, then walks through several register settings. Each
// setting gets directed lookups at the span edges and coordinate extremes,
// then a random mix of lookups and grid writes, with bursty input and a
// stalling receiver. Results are checked by a separate checker module.
// ---------------------------------------------------------------------------
module tb;
    import bgi_pkg::*;

    // Idle wait after the last result, with margin over the pipeline depth.
    localparam int DRAIN_CYCLES = 60;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // entry_addr[7:0], entry_value[23:8], x_pos[55:24], y_pos[87:56]
    logic [S_DATA_W-1:0]   s_tdata;
    // mode[0]
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // z_value[15:0]
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count, pending_count, lookups_checked;
    int burst_left;
    int stall_style;
    int settings_run;

    // Shadow of the current setting, used to aim coordinates at the span.
    int cur_cols, cur_rows, cur_cstep, cur_rstep, cur_fcol, cur_frow;

    bilinear_grid_interpolator_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bgi_result_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .lookups_checked(lookups_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver periodically picks one of always ready, a coin flip, and
    // mostly stalled, so stalls land on every pipeline phase.
    initial begin
        int cyc;
        m_tready    = 1'b0;
        stall_style = 0;
        cyc         = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 200 == 0) stall_style = $urandom_range(0, 2);
            case (stall_style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Generous guard: the slowest correct run stays far below this.
    initial begin
        #3ms;
        $display("timeout waiting for the core");
        $display("status: fail");
        $finish;
    end

    // Offers one item and holds it until the transfer completes. Between
    // bursts the valid drops for a random gap.
    task automatic send_item(logic mode, logic [7:0] addr, logic [15:0] value,
                             logic [31:0] xp, logic [31:0] yp);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {yp, xp, value, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 12);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic lookup(logic [31:0] xp, logic [31:0] yp);
        send_item(MODE_LOOKUP, 8'($urandom), 16'($urandom), xp, yp);
    endtask

    // Drains every expected result, then lets any trailing grid write leave
    // the pipeline, so that registers are only written while the core is idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(int cols, int rows, int cstep, int rstep,
                                 int fcol, int frow);
        int vals [6];
        vals = '{cols, rows, cstep, rstep, fcol, frow};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i][15:0];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
        cur_cols  = (cols & 31) < 1 ? 1 : ((cols & 31) > 16 ? 16 : (cols & 31));
        cur_rows  = (rows & 31) < 1 ? 1 : ((rows & 31) > 16 ? 16 : (rows & 31));
        cur_cstep = cstep & 32'h7fff;
        cur_rstep = rstep & 32'h7fff;
        cur_fcol  = int'($signed(fcol[15:0]));
        cur_frow  = int'($signed(frow[15:0]));
        settings_run++;
    endtask

    // A coordinate near the span: mostly inside it, sometimes just outside.
    function automatic logic [31:0] near_span(int first, int step, int count);
        int span;
        span = (count - 1) * step;
        return first + int'($urandom_range(0, span + 400)) - 200;
    endfunction

    function automatic logic [31:0] pick_coord(int first, int step, int count);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return near_span(first, step, count);
        if (r < 8) return $urandom;
        return r == 8 ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    // Edges of the current span, the coordinate extremes, and points near and inside it.
    task automatic directed_lookups();
        int xe, ye;
        xe = cur_fcol + (cur_cols - 1) * cur_cstep;
        ye = cur_frow + (cur_rows - 1) * cur_rstep;
        lookup(32'h8000_0000, 32'h8000_0000);
        lookup(32'h7fff_ffff, 32'h7fff_ffff);
        lookup(32'h8000_0000, 32'h7fff_ffff);
        lookup(cur_fcol, cur_frow);
        lookup(xe, ye);
        lookup(xe - 1, cur_frow + 1);
        lookup(cur_fcol + cur_cstep / 2, cur_frow + cur_rstep / 3);
        lookup(near_span(cur_fcol, cur_cstep, cur_cols), near_span(cur_frow, cur_rstep, cur_rows));
    endtask

    task automatic random_items(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
                send_item(MODE_WRITE, 8'($urandom), 16'($urandom), $urandom, $urandom);
            else
                lookup(pick_coord(cur_fcol, cur_cstep, cur_cols),
                       pick_coord(cur_frow, cur_rstep, cur_rows));
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        burst_left   = 0;
        settings_run = 0;
        cur_cols = 1; cur_rows = 1; cur_cstep = 0; cur_rstep = 0; cur_fcol = 0; cur_frow = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every entry is written first, so no lookup ever reads an unwritten one.
        // Entries 0, 1 and 16 get the sample extremes.
        for (int a = 0; a < 256; a++) begin
            logic [15:0] v;
            v = (a == 0) ? 16'h8000 : (a == 1) ? 16'h7fff : (a == 16) ? 16'h7fff
              : 16'($urandom);
            send_item(MODE_WRITE, a[7:0], v, $urandom, $urandom);
        end

        // Registers at their reset values: both steps zero, so every lookup gives 0.
        directed_lookups();
        random_items(25);
        wait_idle();

        apply_setting(4, 3, 100, 200, -50, 30);
        directed_lookups();
        random_items(55);
        wait_idle();

        // Extremes: widest grid, largest steps, span end wraps around 16 bits.
        apply_setting(16, 16, 32767, 32767, -32768, 32767);
        directed_lookups();
        random_items(55);
        wait_idle();

        apply_setting(1, 1, 1, 1, 0, 0);
        directed_lookups();
        random_items(35);
        wait_idle();

        // Counts outside 1..16 are clamped by the core.
        apply_setting(0, 31, 5, 7, 100, -100);
        directed_lookups();
        random_items(45);
        wait_idle();

        apply_setting(16, 16, 3000, 2500, -20000, -20000);
        directed_lookups();
        random_items(70);
        wait_idle();

        // The wrapped span end lies below the first column position.
        apply_setting(16, 2, 5000, 1, 30000, 0);
        directed_lookups();
        random_items(55);
        wait_idle();

        // Only the column step is zero.
        apply_setting(8, 8, 0, 300, 0, 0);
        directed_lookups();
        random_items(25);
        wait_idle();

        apply_setting(17, 5, 1, 32767, 32767, -32768);
        directed_lookups();
        random_items(55);
        wait_idle();

        $display("ran %0d register settings after filling the grid", settings_run);
        $display("checked %0d lookup results from bursty input and a stalling receiver",
                 lookups_checked);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/bgi_pkg.sv
design/bgi_ram.sv
design/bgi_div2.sv
design/bgi_blend.sv
design/bilinear_grid_interpolator_core.sv
design/bgi_checker.sv
test/bgi_result_checker.sv
test/tb.sv
